@@ design/prbs_chk_pkg.sv @@
`default_nettype none
package prbs_chk_pkg;

  localparam int WORD_W    = 32;
  localparam int HALF_W    = 16;
  localparam int TAP_REGS  = 4;
  localparam int MAX_TAPS  = 4;
  localparam int TAP_POS_W = 5;
  localparam int TAP_CNT_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 5;
  localparam int STATUS_W  = 2;
  localparam int MIN_WORDS = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WORD_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_POS_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_POS_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_POS_C  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_POS_D  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SEQ     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_PAYLOAD = 2'd3;

  typedef logic [TAP_POS_W-1:0] tap_pos_t;

  typedef struct packed {
    logic                           word_width_sel;
    logic [TAP_CNT_W-1:0]           tap_count;
    tap_pos_t [TAP_REGS-1:0]        tap_pos;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   error_index;
    logic [WORD_W-1:0]   expected_value;
    logic [WORD_W-1:0]   received_value;
  } res_t;

endpackage
`default_nettype wire

@@ design/prbs_chk_lfsr_step.sv @@
`default_nettype none
module prbs_chk_lfsr_step (
  input  wire prbs_chk_pkg::cfg_t              cfg,
  input  wire logic [prbs_chk_pkg::WORD_W-1:0] cur_value,
  output logic [prbs_chk_pkg::WORD_W-1:0]      next_value
);
  import prbs_chk_pkg::*;

  localparam int TAP_LIMIT = (MAX_TAPS < TAP_REGS) ? MAX_TAPS : TAP_REGS;
  localparam int NT_W = TAP_CNT_W + 1;

  logic [NT_W-1:0] taps_used;
  logic            feedback;

  // clamp the tap count to what the hardware supports
  assign taps_used = ({1'b0, cfg.tap_count} > NT_W'(TAP_LIMIT)) ?
                     NT_W'(TAP_LIMIT) : {1'b0, cfg.tap_count};

  always_comb begin
    feedback = 1'b0;
    for (int i = 0; i < TAP_REGS; i++) begin
      if (NT_W'(i) < taps_used) begin
        feedback = feedback ^ cur_value[cfg.tap_pos[i]];
      end
    end
  end

  assign next_value = {cur_value[WORD_W-2:0], feedback};

endmodule
`default_nettype wire

@@ design/prbs_chk_tracker.sv @@
`default_nettype none
module prbs_chk_tracker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire prbs_chk_pkg::cfg_t              cfg,
  input  wire logic                            step,
  input  wire logic [prbs_chk_pkg::WORD_W-1:0] data_word,
  input  wire logic                            last_word,
  output logic                                 result_valid,
  output prbs_chk_pkg::res_t                   result
);
  import prbs_chk_pkg::*;

  logic [WORD_W-1:0] stored_sequence, stored_sequence_next;
  logic [WORD_W-1:0] lfsr_value, lfsr_value_next;
  logic [WORD_W-1:0] word_counter, word_counter_next;
  logic [WORD_W-1:0] header_sequence, header_sequence_next;
  logic [WORD_W-1:0] length_field, length_field_next;
  logic              mismatch_seen, mismatch_seen_next;
  logic [WORD_W-1:0] mismatch_index, mismatch_index_next;
  logic [WORD_W-1:0] mismatch_expected, mismatch_expected_next;
  logic [WORD_W-1:0] mismatch_received, mismatch_received_next;

  logic [WORD_W-1:0] mask, data, lfsr_stepped, count_inc;
  logic              size_bad, seq_bad;

  prbs_chk_lfsr_step u_lfsr (
    .cfg        (cfg),
    .cur_value  (lfsr_value),
    .next_value (lfsr_stepped)
  );

  assign mask = cfg.word_width_sel ? {WORD_W{1'b1}} : {{(WORD_W-HALF_W){1'b0}}, {HALF_W{1'b1}}};
  assign data = data_word & mask;
  assign count_inc = (&word_counter) ? word_counter : word_counter + 1'b1;

  always_comb begin
    header_sequence_next   = header_sequence;
    length_field_next      = length_field;
    lfsr_value_next        = lfsr_value;
    mismatch_seen_next     = mismatch_seen;
    mismatch_index_next    = mismatch_index;
    mismatch_expected_next = mismatch_expected;
    mismatch_received_next = mismatch_received;
    stored_sequence_next   = stored_sequence;

    if (word_counter == '0) begin
      header_sequence_next = data;
      lfsr_value_next      = data;
    end else if (word_counter == WORD_W'(1)) begin
      length_field_next = data;
    end else begin
      lfsr_value_next = lfsr_stepped;
      if (!mismatch_seen && ((lfsr_stepped & mask) != data)) begin
        mismatch_seen_next     = 1'b1;
        mismatch_index_next    = word_counter;
        mismatch_expected_next = lfsr_stepped & mask;
        mismatch_received_next = data;
      end
    end

    // length compare is done one bit wider so length+1 cannot wrap
    size_bad = (&count_inc) || (count_inc < WORD_W'(MIN_WORDS)) ||
               ({1'b0, count_inc} != ({1'b0, length_field_next} + 33'd1));
    seq_bad  = (stored_sequence != '0) && (stored_sequence != header_sequence_next);

    result = '0;
    if (size_bad) begin
      result.status = ST_BAD_SIZE;
    end else if (seq_bad) begin
      result.status        = ST_BAD_SEQ;
      stored_sequence_next = header_sequence_next + 1'b1;
    end else begin
      stored_sequence_next = header_sequence_next + 1'b1;
      if (mismatch_seen_next) begin
        result.status         = ST_BAD_PAYLOAD;
        result.error_index    = mismatch_index_next;
        result.expected_value = mismatch_expected_next;
        result.received_value = mismatch_received_next;
      end else begin
        result.status = ST_OK;
      end
    end

    word_counter_next = count_inc;
    if (last_word) begin
      word_counter_next      = '0;
      mismatch_seen_next     = 1'b0;
      mismatch_index_next    = '0;
      mismatch_expected_next = '0;
      mismatch_received_next = '0;
    end else begin
      stored_sequence_next = stored_sequence;
    end
  end

  assign result_valid = step && last_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_sequence   <= '0;
      lfsr_value        <= '0;
      word_counter      <= '0;
      header_sequence   <= '0;
      length_field      <= '0;
      mismatch_seen     <= 1'b0;
      mismatch_index    <= '0;
      mismatch_expected <= '0;
      mismatch_received <= '0;
    end else if (step) begin
      stored_sequence   <= stored_sequence_next;
      lfsr_value        <= lfsr_value_next;
      word_counter      <= word_counter_next;
      header_sequence   <= header_sequence_next;
      length_field      <= length_field_next;
      mismatch_seen     <= mismatch_seen_next;
      mismatch_index    <= mismatch_index_next;
      mismatch_expected <= mismatch_expected_next;
      mismatch_received <= mismatch_received_next;
    end
  end

  // a payload mismatch can only sit at word index 2 or later
  a_mismatch_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_BAD_PAYLOAD) |-> result.error_index >= WORD_W'(2))
    else $error("payload mismatch reported inside the header");

  a_counter_clears: assert property (@(posedge clk) disable iff (rst)
    step && last_word |=> word_counter == '0 && !mismatch_seen)
    else $error("frame state not cleared after last beat");

endmodule
`default_nettype wire

@@ design/prbs_frame_checker_core.sv @@
// PRBS frame checker.
// Input channel (in_valid/in_ready): one frame word per beat, data_word plus
// last_word on the final beat. Word 0 is the sequence number, word 1 the
// length, the rest is LFSR payload seeded by the sequence number.
// Output channel (out_valid/out_ready): one status beat per frame, sent after
// the beat that carried last_word, with the first payload mismatch details.
// Config port: cfg_write/cfg_index/cfg_data; the user must write it only while idle, as the block has no check for it.
// Throughput: one word per clock, unless a last beat waits for the result
// register; the LFSR step and compare sit combinationally between the input
// register and the result register.
// A stalled receiver holds the result register; payload beats keep flowing
// through the input register, and only a further last beat waits for the
// result register to drain.
// Reset clears the frame state, the stored sequence and both stages, and
// loads the default taps (1, 2, 6, 31, four in use) and 32-bit words.
`default_nettype none
module prbs_frame_checker_core (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_write,
  input  wire logic [prbs_chk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [prbs_chk_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic [prbs_chk_pkg::WORD_W-1:0]         data_word,
  input  wire logic                                    last_word,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic [prbs_chk_pkg::STATUS_W-1:0]            status,
  output logic [prbs_chk_pkg::WORD_W-1:0]              error_index,
  output logic [prbs_chk_pkg::WORD_W-1:0]              expected_value,
  output logic [prbs_chk_pkg::WORD_W-1:0]              received_value
);
  import prbs_chk_pkg::*;

  cfg_t              cfg;
  logic              s_valid;
  logic [WORD_W-1:0] s_data;
  logic              s_last;
  logic              s_step;
  logic              res_valid;
  res_t              res;
  res_t              out_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.word_width_sel <= 1'b1;
      cfg.tap_count      <= TAP_CNT_W'(4);
      cfg.tap_pos[0]     <= TAP_POS_W'(1);
      cfg.tap_pos[1]     <= TAP_POS_W'(2);
      cfg.tap_pos[2]     <= TAP_POS_W'(6);
      cfg.tap_pos[3]     <= TAP_POS_W'(31);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WORD_WIDTH: cfg.word_width_sel <= cfg_data[0];
        REG_TAP_COUNT:  cfg.tap_count      <= cfg_data[TAP_CNT_W-1:0];
        REG_TAP_POS_A:  cfg.tap_pos[0]     <= cfg_data[TAP_POS_W-1:0];
        REG_TAP_POS_B:  cfg.tap_pos[1]     <= cfg_data[TAP_POS_W-1:0];
        REG_TAP_POS_C:  cfg.tap_pos[2]     <= cfg_data[TAP_POS_W-1:0];
        REG_TAP_POS_D:  cfg.tap_pos[3]     <= cfg_data[TAP_POS_W-1:0];
        default: ;
      endcase
    end
  end

  // only a last beat needs room in the result register
  assign s_step   = s_valid && (!s_last || !out_valid || out_ready);
  assign in_ready = !s_valid || s_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_data <= data_word;
      s_last <= last_word;
    end
  end

  prbs_chk_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .step         (s_step),
    .data_word    (s_data),
    .last_word    (s_last),
    .result_valid (res_valid),
    .result       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign status         = out_res.status;
  assign error_index    = out_res.error_index;
  assign expected_value = out_res.expected_value;
  assign received_value = out_res.received_value;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !out_valid || out_ready)
    else $error("status beat overwritten before it was taken");

  a_detail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_BAD_PAYLOAD) |->
      error_index == '0 && expected_value == '0 && received_value == '0)
    else $error("mismatch detail on a non-payload status");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s_valid && !s_step |=> s_valid && $stable(s_data) && $stable(s_last))
    else $error("input stage dropped a stalled beat");

endmodule
`default_nettype wire
